[design/kscle_pkg.sv]
// ============================================================================
// Scan-code line editor package
// Event codes, scan codes, register map and the layout character table
// shared by the line editor.
// ============================================================================
`default_nettype none

package kscle_pkg;

    // Longest line the editor supports, caps the configured limit.
    localparam int unsigned MAX_LINE = 255;
    localparam int unsigned LIMIT_CAP = (MAX_LINE > 255) ? 255 : MAX_LINE;

    // Widths of the transaction fields.
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    // Reset values of the configuration registers.
    localparam logic       LAYOUT_RESET = 1'b0;
    localparam logic [7:0] LIMIT_RESET  = 8'd60;

    // Register indexes (byte address bit 2 selects the register).
    localparam logic REG_LAYOUT = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    // Event kinds reported on the result channel.
    localparam logic [KIND_W-1:0] EV_NONE     = 3'd0;
    localparam logic [KIND_W-1:0] EV_CHAR     = 3'd1;
    localparam logic [KIND_W-1:0] EV_ERASE    = 3'd2;
    localparam logic [KIND_W-1:0] EV_LEFT     = 3'd3;
    localparam logic [KIND_W-1:0] EV_RIGHT    = 3'd4;
    localparam logic [KIND_W-1:0] EV_LINE_END = 3'd5;
    localparam logic [KIND_W-1:0] EV_ESCAPE   = 3'd6;
    localparam logic [KIND_W-1:0] EV_TAB      = 3'd7;

    // Scan set 1 make codes with a special meaning.
    localparam logic [CODE_W-1:0] SC_ESC      = 8'd1;
    localparam logic [CODE_W-1:0] SC_BKSP     = 8'd14;
    localparam logic [CODE_W-1:0] SC_TAB      = 8'd15;
    localparam logic [CODE_W-1:0] SC_ENTER    = 8'd28;
    localparam logic [CODE_W-1:0] SC_LSHIFT   = 8'd42;
    localparam logic [CODE_W-1:0] SC_RSHIFT   = 8'd54;
    localparam logic [CODE_W-1:0] SC_CAPS     = 8'd58;
    localparam logic [CODE_W-1:0] SC_KP_MINUS = 8'd74;
    localparam logic [CODE_W-1:0] SC_LEFT     = 8'd75;
    localparam logic [CODE_W-1:0] SC_RIGHT    = 8'd77;
    localparam logic [CODE_W-1:0] SC_KP_PLUS  = 8'd78;
    localparam logic [CODE_W-1:0] SC_TABLE_MAX = 8'd57;

    // Characters reported with escape and tab.
    localparam logic [CHAR_W-1:0] CH_ESC = 8'd27;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;

    // Picks one of four table entries by {layout, shift}.
    function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] us,
                                        input logic [7:0] us_sh, input logic [7:0] de,
                                        input logic [7:0] de_sh);
        logic [7:0] c;
        case (sel)
            2'd0:    c = us;
            2'd1:    c = us_sh;
            2'd2:    c = de;
            default: c = de_sh;
        endcase
        return c;
    endfunction

    // Letter key: upper case while shift is active.
    function automatic logic [7:0] letter(input logic shift, input logic [7:0] lc);
        return shift ? (lc - 8'd32) : lc;
    endfunction

    // Character table for make codes 0 to 57, zero where no character.
    function automatic logic [7:0] char_lookup(input logic [1:0] sel, input logic [5:0] idx);
        logic [7:0] c;
        case (idx)
            6'd2:  c = pick(sel, "1", "!", "1", "!");
            6'd3:  c = pick(sel, "2", "@", "2", 8'h22);
            6'd4:  c = pick(sel, "3", "#", "3", 8'hF5);
            6'd5:  c = pick(sel, "4", "$", "4", "$");
            6'd6:  c = pick(sel, "5", "%", "5", "%");
            6'd7:  c = pick(sel, "6", "^", "6", "&");
            6'd8:  c = pick(sel, "7", "&", "7", "/");
            6'd9:  c = pick(sel, "8", "*", "8", "(");
            6'd10: c = pick(sel, "9", "(", "9", ")");
            6'd11: c = pick(sel, "0", ")", "0", "=");
            6'd12: c = pick(sel, "-", "_", 8'hE1, "?");
            6'd13: c = pick(sel, "=", "+", 8'hEF, 8'h60);
            6'd16: c = letter(sel[0], "q");
            6'd17: c = letter(sel[0], "w");
            6'd18: c = letter(sel[0], "e");
            6'd19: c = letter(sel[0], "r");
            6'd20: c = letter(sel[0], "t");
            6'd21: c = letter(sel[0], sel[1] ? "z" : "y");
            6'd22: c = letter(sel[0], "u");
            6'd23: c = letter(sel[0], "i");
            6'd24: c = letter(sel[0], "o");
            6'd25: c = letter(sel[0], "p");
            6'd26: c = pick(sel, "[", "{", 8'h81, 8'h9A);
            6'd27: c = pick(sel, "]", "}", "+", "*");
            6'd30: c = letter(sel[0], "a");
            6'd31: c = letter(sel[0], "s");
            6'd32: c = letter(sel[0], "d");
            6'd33: c = letter(sel[0], "f");
            6'd34: c = letter(sel[0], "g");
            6'd35: c = letter(sel[0], "h");
            6'd36: c = letter(sel[0], "j");
            6'd37: c = letter(sel[0], "k");
            6'd38: c = letter(sel[0], "l");
            6'd39: c = pick(sel, ";", ":", 8'h94, 8'h99);
            6'd40: c = pick(sel, 8'h27, 8'h22, 8'h84, 8'h8E);
            6'd41: c = pick(sel, 8'h60, "~", "^", 8'hA7);
            6'd43: c = pick(sel, 8'h5C, "|", "#", 8'h27);
            6'd44: c = letter(sel[0], sel[1] ? "y" : "z");
            6'd45: c = letter(sel[0], "x");
            6'd46: c = letter(sel[0], "c");
            6'd47: c = letter(sel[0], "v");
            6'd48: c = letter(sel[0], "b");
            6'd49: c = letter(sel[0], "n");
            6'd50: c = letter(sel[0], "m");
            6'd51: c = pick(sel, ",", "<", ",", ";");
            6'd52: c = pick(sel, ".", ">", ".", ":");
            6'd53: c = pick(sel, "/", "?", "-", "_");
            6'd55: c = "*";
            6'd57: c = " ";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[design/keyboard_scancode_line_editor.sv]
// ============================================================================
// Keyboard scan-code line editor
// Translates scan set 1 make codes into line editing events with an
// English US or German layout, a shift flag and a bounded cursor.
// ============================================================================
//
// Usage:
//   The input stream carries one scan code byte per transaction on s_tdata.
//   Every accepted code produces exactly one result transaction: the event
//   kind on m_tuser, and the character and line position on m_tdata.
//   Two registers are set over the APB port at byte addresses 0 (layout)
//   and 4 (line limit); they are to be written only while the block is
//   idle; the block itself does not enforce this. A code is held in the
//   input register, then processed into the result register and shown
//   from there. Throughput is one code per cycle while results are taken;
//   the cursor and shift flag update in the same cycle the code is processed,
//   so consecutive codes see each other's effect without a gap.
//   Reset clears the cursor and shift flag, selects the English layout and
//   sets the line limit to 60. When the receiver stalls, the result holds,
//   one more code is taken into the input register, and then s_tready drops
//   until the result is taken.
//
`default_nettype none

module keyboard_scancode_line_editor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream: [7:0] scan_code
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,
    // Result stream: [7:0] char_code, [15:8] position
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,
    // Result kind: [2:0] event_kind
    output logic [kscle_pkg::KIND_W-1:0]         m_tuser,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kscle_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [kscle_pkg::DATA_W-1:0]    pwdata,
    output logic [kscle_pkg::DATA_W-1:0]         prdata,
    output logic                                 pready
);
    import kscle_pkg::*;

    logic                 layout_reg;
    logic [7:0]           limit_reg;
    logic                 shift_reg;
    logic [POS_W-1:0]     cursor_reg;
    logic                 in_valid_reg;
    logic [CODE_W-1:0]    in_code_reg;
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [POS_W-1:0]     out_pos_reg;

    logic                 shift_next;
    logic [POS_W-1:0]     cursor_next;
    logic [KIND_W-1:0]    kind_next;
    logic [CHAR_W-1:0]    char_next;
    logic [POS_W-1:0]     pos_next;
    logic [7:0]           limit_eff;
    logic                 line_full;
    logic [CHAR_W-1:0]    key_char;
    logic                 move;
    logic                 cfg_write;

    // Configuration port: always ready, register chosen by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_LAYOUT: prdata = {{(DATA_W-1){1'b0}}, layout_reg};
            default:    prdata = {{(DATA_W-8){1'b0}}, limit_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= LAYOUT_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LAYOUT) begin
                layout_reg <= pwdata[0];
            end else begin
                limit_reg <= pwdata[7:0];
            end
        end
    end

    // Handshake: the input register drains into the result register.
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata;
        end
    end

    // Effective limit and the line-full condition.
    assign limit_eff = (limit_reg > 8'(LIMIT_CAP)) ? 8'(LIMIT_CAP) : limit_reg;
    assign line_full = cursor_reg >= limit_eff;

    // Character of a printable key, keypad minus and plus are layout free.
    always_comb begin
        if (in_code_reg == SC_KP_MINUS) begin
            key_char = "-";
        end else if (in_code_reg == SC_KP_PLUS) begin
            key_char = "+";
        end else if (in_code_reg <= SC_TABLE_MAX) begin
            key_char = char_lookup({layout_reg, shift_reg}, in_code_reg[5:0]);
        end else begin
            key_char = 8'd0;
        end
    end

    // Event decode and next cursor and shift state.
    always_comb begin
        shift_next  = shift_reg;
        cursor_next = cursor_reg;
        kind_next   = EV_NONE;
        char_next   = 8'd0;
        pos_next    = cursor_reg;
        if (!in_code_reg[7]) begin
            case (in_code_reg) inside
                SC_ESC: begin
                    kind_next   = EV_ESCAPE;
                    char_next   = CH_ESC;
                    cursor_next = '0;
                    shift_next  = 1'b0;
                end
                SC_ENTER: begin
                    kind_next   = EV_LINE_END;
                    cursor_next = '0;
                    shift_next  = 1'b0;
                end
                SC_BKSP, SC_LEFT: begin
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_reg - 1'b1;
                        pos_next    = cursor_reg - 1'b1;
                        kind_next   = (in_code_reg == SC_BKSP) ? EV_ERASE : EV_LEFT;
                    end
                end
                SC_TAB: begin
                    if (!line_full) begin
                        kind_next   = EV_TAB;
                        char_next   = CH_TAB;
                        cursor_next = '0;
                        shift_next  = 1'b0;
                    end
                end
                SC_LSHIFT, SC_RSHIFT, SC_CAPS: begin
                    if (!line_full) begin
                        shift_next = !shift_reg;
                    end
                end
                SC_RIGHT: begin
                    if (!line_full) begin
                        cursor_next = cursor_reg + 1'b1;
                        pos_next    = cursor_reg + 1'b1;
                        kind_next   = EV_RIGHT;
                    end
                end
                default: begin
                    if (!line_full && key_char != 8'd0) begin
                        kind_next   = EV_CHAR;
                        char_next   = key_char;
                        cursor_next = cursor_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // Editor state advances once per processed code.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 1'b0;
            cursor_reg <= '0;
        end else if (move) begin
            shift_reg  <= shift_next;
            cursor_reg <= cursor_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_kind_reg <= kind_next;
            out_char_reg <= char_next;
            out_pos_reg  <= pos_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_pos_reg, out_char_reg};

`ifndef SYNTHESIS
    // A character event always carries a character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg == EV_CHAR |-> out_char_reg != 8'd0)
        else $error("char event without a character");

    // Only char, escape and tab events carry a character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != EV_CHAR && out_kind_reg != EV_ESCAPE &&
        out_kind_reg != EV_TAB |-> out_char_reg == 8'd0)
        else $error("character on a non-character event");

    // Ending a line, escape and tab clear the cursor and the shift flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        move && (kind_next == EV_LINE_END || kind_next == EV_ESCAPE ||
        kind_next == EV_TAB) |=> cursor_reg == '0 && !shift_reg)
        else $error("line end did not clear the editor state");

    // Erase and left step the cursor back by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        move && (kind_next == EV_ERASE || kind_next == EV_LEFT) |=>
        cursor_reg == $past(cursor_reg) - 1'b1)
        else $error("erase or left moved the cursor wrongly");

    // A pending code stays put while the result register is blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !move |=> in_valid_reg && $stable(in_code_reg))
        else $error("pending scan code lost");
`endif

endmodule

`default_nettype wire
